### design/plbd_pkg.sv
// Shared types and constants for the palette lookup and box downsample block.
package plbd_pkg;

   // Palette and row-sum store sizes.
   localparam int PALETTE_ENTRIES  = 1024;
   localparam int LUT_AW           = $clog2(PALETTE_ENTRIES);
   localparam int MAX_SOURCE_WIDTH = 2048;
   localparam int ROW_DEPTH        = MAX_SOURCE_WIDTH / 2;
   localparam int ROW_AW           = $clog2(ROW_DEPTH);
   localparam int COL_W            = 11;
   localparam int WIDTH_W          = 11;

   // Color and sum widths.
   localparam int COLOR_W = 24;
   localparam int SUM_W   = 27;

   // Result queue sizing.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = FIFO_AW + 1;

   // Item function codes.
   localparam logic FUNC_LUT_WRITE = 1'b0;
   localparam logic FUNC_SAMPLE    = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SCALE_FACTOR   = 2'd0;
   localparam logic [1:0] CSR_BASE_OFFSET    = 2'd1;
   localparam logic [1:0] CSR_OUT_ROW_PIXELS = 2'd2;

   // Configuration reset values.
   localparam logic [31:0]        SCALE_RESET = 32'h0001_0000;
   localparam logic [31:0]        BASE_RESET  = 32'h0000_0000;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1024);

   // One input item.
   typedef struct packed {
      logic               func;
      logic [9:0]         lut_index;
      logic [7:0]         lut_red;
      logic [7:0]         lut_green;
      logic [7:0]         lut_blue;
      logic signed [31:0] escape_count;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
   } rsp_type;

endpackage

### design/palette_lut_box_downsample.sv
// Top level: palette lookup of escape counts followed by a 2x2 box downsample.
//
//   Channel  Signals                          Direction  Carries
//   req      req_valid, req_stall, req_payload  in       lut-write or sample item
//   rsp      rsp_valid, rsp_stall, rsp_payload  out      averaged 2x2 pixel
//   csr      csr_valid, csr_ready, csr_index,   in       register write
//            csr_wdata
//
// One item is accepted per clock while req_stall is low. The sample that
// completes a block reaches rsp through subtract, multiply, palette read,
// pair sum with row-sum read, and the result queue.
// Reset is synchronous; it clears the stream position and the queue but not
// the palette or the row-sum store, which hold garbage until written.
// req_stall rises only when all eight result queue slots are spoken for by
// queued results or by samples still in the pipeline.
module palette_lut_box_downsample (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  plbd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output plbd_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import plbd_pkg::*;

   // Configuration registers.
   logic [31:0]        scale_ff;
   logic [31:0]        base_ff;
   logic [WIDTH_W-1:0] width_ff;

   // Handshake terms.
   logic req_accept;
   logic rsp_pop;

   // Stage 1: offset count.
   logic        v1_ff;
   logic        func1_ff;
   logic        neg1_ff;
   logic [31:0] d1_ff;
   logic [9:0]  idx1_ff;
   logic [COLOR_W-1:0] rgb1_ff;

   // Stage 2: wrapped fraction, palette access.
   logic        v2_ff;
   logic        func2_ff;
   logic        neg2_ff;
   logic [31:0] frac2_ff;
   logic [31:0] prod;
   logic [9:0]  idx2_ff;
   logic [COLOR_W-1:0] rgb2_ff;
   logic        pal_we;
   logic [COLOR_W-1:0] pal_rdata;

   // Stage 3: shaded color, pair logic, row-sum access.
   logic        v3_ff;
   logic        neg3_ff;
   logic [COLOR_W-1:0] color;
   logic [COL_W-1:0]   column_ff, column_in;
   logic [COLOR_W-1:0] left_ff, left_in;
   logic        parity_ff, parity_in;
   logic        right_pair;
   logic [WIDTH_W-1:0] width_eff;
   logic [COL_W-2:0]   pos_full;
   logic [ROW_AW-1:0]  pos;
   logic        last;
   logic [8:0]  sum_r, sum_g, sum_b;
   logic [SUM_W-1:0]   sum;
   logic        row_we;
   logic [SUM_W-1:0]   row_rdata;
   logic        release_slot;
   logic        v4_in;

   // Stage 4: finish the block average.
   logic        v4_ff;
   logic        last4_ff;
   logic [SUM_W-1:0] sum4_ff;
   logic [9:0]  tot_r, tot_g, tot_b;
   rsp_type     push_data;

   // Result slot reservations.
   logic [FIFO_CW-1:0] reserved_ff, reserved_in;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (reserved_ff >= FIFO_CW'(FIFO_DEPTH));
   assign rsp_pop    = rsp_valid && !rsp_stall;
   assign csr_ready  = 1'b1;

   // Configuration writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         base_ff  <= BASE_RESET;
         width_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCALE_FACTOR:   scale_ff <= csr_wdata;
            CSR_BASE_OFFSET:    base_ff  <= csr_wdata;
            CSR_OUT_ROW_PIXELS: width_ff <= csr_wdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   // The low half of the product is the wrapped fraction; it depends only
   // on the low 32 bits of both factors.
   assign prod = scale_ff * d1_ff;

   // Palette: a write item writes at stage 2, a sample reads there.
   assign pal_we = v2_ff && (func2_ff == FUNC_LUT_WRITE) &&
                   (32'(idx2_ff) < PALETTE_ENTRIES);

   plbd_ram #(
      .WIDTH(COLOR_W),
      .DEPTH(PALETTE_ENTRIES)
   ) u_palette (
      .clock  (clock),
      .wr_en  (pal_we),
      .wr_addr(idx2_ff[LUT_AW-1:0]),
      .wr_data(rgb2_ff),
      .rd_addr(frac2_ff[31 -: LUT_AW]),
      .rd_data(pal_rdata)
   );

   // Stage 3: shade, pair the samples and track the row position.
   always_comb begin
      color = neg3_ff ? '0 : pal_rdata;
      right_pair = column_ff[0];

      width_eff = width_ff;
      if (width_ff == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (32'(width_ff) > ROW_DEPTH) begin
         width_eff = WIDTH_W'(ROW_DEPTH);
      end

      pos_full = column_ff[COL_W-1:1];
      last     = ({1'b0, pos_full} >= (width_eff - WIDTH_W'(1)));
      pos      = (32'(pos_full) >= ROW_DEPTH) ? ROW_AW'(ROW_DEPTH - 1)
                                              : pos_full[ROW_AW-1:0];

      sum_r = {1'b0, left_ff[23:16]} + {1'b0, color[23:16]};
      sum_g = {1'b0, left_ff[15:8]}  + {1'b0, color[15:8]};
      sum_b = {1'b0, left_ff[7:0]}   + {1'b0, color[7:0]};
      sum   = {sum_r, sum_g, sum_b};

      column_in    = column_ff;
      left_in      = left_ff;
      parity_in    = parity_ff;
      row_we       = 1'b0;
      v4_in        = 1'b0;
      release_slot = 1'b0;

      if (v3_ff) begin
         if (!right_pair) begin
            left_in      = color;
            column_in    = column_ff + COL_W'(1);
            release_slot = 1'b1;
         end else begin
            column_in = last ? '0 : column_ff + COL_W'(1);
            if (!parity_ff) begin
               row_we       = 1'b1;
               release_slot = 1'b1;
               if (last) begin
                  parity_in = 1'b1;
               end
            end else begin
               v4_in = 1'b1;
               if (last) begin
                  parity_in = 1'b0;
               end
            end
         end
      end
   end

   // Row-sum store: first row of a pair writes, second row reads.
   plbd_ram #(
      .WIDTH(SUM_W),
      .DEPTH(ROW_DEPTH)
   ) u_row_sums (
      .clock  (clock),
      .wr_en  (row_we),
      .wr_addr(pos),
      .wr_data(sum),
      .rd_addr(pos),
      .rd_data(row_rdata)
   );

   // Stage 4: add both rows and divide by four.
   always_comb begin
      tot_r = {1'b0, row_rdata[26:18]} + {1'b0, sum4_ff[26:18]};
      tot_g = {1'b0, row_rdata[17:9]}  + {1'b0, sum4_ff[17:9]};
      tot_b = {1'b0, row_rdata[8:0]}   + {1'b0, sum4_ff[8:0]};
      push_data.red     = tot_r[9:2];
      push_data.green   = tot_g[9:2];
      push_data.blue    = tot_b[9:2];
      push_data.row_end = last4_ff;
   end

   // A sample reserves a result slot on entry; the slot is freed when the
   // sample turns out to give no result, or when its result is taken.
   always_comb begin
      reserved_in = reserved_ff;
      if (req_accept && (req_payload.func == FUNC_SAMPLE)) begin
         reserved_in = reserved_in + FIFO_CW'(1);
      end
      if (release_slot) begin
         reserved_in = reserved_in - FIFO_CW'(1);
      end
      if (rsp_pop) begin
         reserved_in = reserved_in - FIFO_CW'(1);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         column_ff   <= '0;
         left_ff     <= '0;
         parity_ff   <= 1'b0;
         reserved_ff <= '0;
      end else begin
         v1_ff       <= req_accept;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff && (func2_ff == FUNC_SAMPLE);
         v4_ff       <= v4_in;
         column_ff   <= column_in;
         left_ff     <= left_in;
         parity_ff   <= parity_in;
         reserved_ff <= reserved_in;
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      func1_ff <= req_payload.func;
      neg1_ff  <= req_payload.escape_count[31];
      d1_ff    <= req_payload.escape_count - base_ff;
      idx1_ff  <= req_payload.lut_index;
      rgb1_ff  <= {req_payload.lut_red, req_payload.lut_green, req_payload.lut_blue};

      func2_ff <= func1_ff;
      neg2_ff  <= neg1_ff;
      frac2_ff <= prod;
      idx2_ff  <= idx1_ff;
      rgb2_ff  <= rgb1_ff;

      neg3_ff  <= neg2_ff;

      sum4_ff  <= sum;
      last4_ff <= last;
   end

   plbd_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (v4_ff),
      .push_data(push_data),
      .pop      (rsp_pop),
      .out_valid(rsp_valid),
      .out_data (rsp_payload)
   );

endmodule

### design/plbd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module plbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### design/plbd_out_fifo.sv
// Small result queue that decouples the pipeline from the result channel.
module plbd_out_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  plbd_pkg::rsp_type push_data,
   input  logic             pop,
   output logic             out_valid,
   output plbd_pkg::rsp_type out_data
);
   import plbd_pkg::*;

   rsp_type             entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  head_ff, head_in;
   logic [FIFO_AW-1:0]  tail_ff, tail_in;
   logic [FIFO_CW-1:0]  count_ff, count_in;

   // Pointer and fill-count updates.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = tail_ff + FIFO_AW'(1);
      end
      if (pop) begin
         head_in  = head_ff + FIFO_AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + FIFO_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[head_ff];

endmodule
